[rtl/core/dlipc_pkg.sv]
`timescale 1ns / 1ps

package dlipc_pkg;

    localparam int unsigned DEBOUNCE_TICKS = 10;
    localparam int unsigned DEB_CNT_W      = 4;
    localparam int unsigned DELAY_W        = 8;
    localparam int unsigned MS_CNT_W       = 18;
    localparam int unsigned MS_W           = 10;
    localparam int unsigned TDATA_W        = 8;

    localparam logic [MS_W-1:0] MS_PER_SEC = MS_W'(1000);

    localparam logic [1:0] CMD_NONE      = 2'd0;
    localparam logic [1:0] CMD_RELAY_ON  = 2'd1;
    localparam logic [1:0] CMD_RELAY_OFF = 2'd2;

    localparam logic [1:0] EVT_NONE       = 2'd0;
    localparam logic [1:0] EVT_LIGHTS_ON  = 2'd1;
    localparam logic [1:0] EVT_LIGHTS_OFF = 2'd2;

    typedef struct packed {
        logic [DEB_CNT_W-1:0] count;
        logic                 level;
    } deb_state_t;

endpackage

[rtl/core/dlipc_debounce.sv]
`timescale 1ns / 1ps

module dlipc_debounce (
    input  logic                  sample,
    input  dlipc_pkg::deb_state_t state_cur,
    output dlipc_pkg::deb_state_t state_next,
    output logic                  flip
);

    logic [dlipc_pkg::DEB_CNT_W-1:0] count_step;

    always_comb begin
        if (sample == state_cur.level) begin
            count_step = (state_cur.count != '0) ? state_cur.count - 1'b1 : state_cur.count;
        end else begin
            count_step = state_cur.count + 1'b1;
        end
        if (count_step >= dlipc_pkg::DEB_CNT_W'(dlipc_pkg::DEBOUNCE_TICKS)) begin
            flip             = 1'b1;
            state_next.count = '0;
            state_next.level = sample;
        end else begin
            flip             = 1'b0;
            state_next.count = count_step;
            state_next.level = state_cur.level;
        end
    end

endmodule

[rtl/core/debounced_lights_ignition_power_control_core.sv]
`timescale 1ns / 1ps

// One request is one millisecond tick carrying raw reverse-light and ignition samples and a
// camera command; each request gives exactly one result with the relay drive, the power drive
// and a lights on/off event. The block takes one request per clock cycle when the result side
// keeps up; each request passes first through an input register and then through a single
// compute stage that updates both debouncers, the relay and the off-delay countdown and writes
// the result register. The off delay (seconds) is written through cfg_wr_en/cfg_wr_data and is
// captured when a countdown starts; a countdown is cancelled when ignition debounces high.

module debounced_lights_ignition_power_control_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [dlipc_pkg::DELAY_W-1:0]  cfg_wr_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // lights_sample [0], ignition_sample [1], command [3:2], zero [7:4]
    input  logic [dlipc_pkg::TDATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // relay_on [0], power_on [1], lights_event [3:2], zero [7:4]
    output logic [dlipc_pkg::TDATA_W-1:0]  m_axis_tdata
);

    logic [dlipc_pkg::DELAY_W-1:0]  off_delay_reg;

    logic                           in_valid_reg;
    logic                           in_lights_reg;
    logic                           in_ign_reg;
    logic [1:0]                     in_cmd_reg;

    logic                           out_valid_reg;
    logic                           out_relay_reg;
    logic                           out_power_reg;
    logic [1:0]                     out_event_reg;

    dlipc_pkg::deb_state_t          lights_reg, lights_next;
    dlipc_pkg::deb_state_t          ign_reg, ign_next;
    logic                           relay_reg, relay_next;
    logic                           power_reg, power_next;
    logic                           cd_active_reg, cd_active_next;
    logic [dlipc_pkg::MS_CNT_W-1:0] cd_ms_reg, cd_ms_next;
    logic [1:0]                     event_next;

    logic                           lights_flip;
    logic                           ign_flip;
    logic                           advance;
    logic [dlipc_pkg::MS_CNT_W-1:0] cd_load;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(dlipc_pkg::TDATA_W-4){1'b0}}, out_event_reg, out_power_reg,
                            out_relay_reg};

    dlipc_debounce u_lights_deb (
        .sample     (in_lights_reg),
        .state_cur  (lights_reg),
        .state_next (lights_next),
        .flip       (lights_flip)
    );

    dlipc_debounce u_ign_deb (
        .sample     (in_ign_reg),
        .state_cur  (ign_reg),
        .state_next (ign_next),
        .flip       (ign_flip)
    );

    assign cd_load = dlipc_pkg::MS_CNT_W'(off_delay_reg)
                   * dlipc_pkg::MS_CNT_W'(dlipc_pkg::MS_PER_SEC);

    always_comb begin
        relay_next     = relay_reg;
        power_next     = power_reg;
        cd_active_next = cd_active_reg;
        cd_ms_next     = cd_ms_reg;
        event_next     = dlipc_pkg::EVT_NONE;

        case (in_cmd_reg)
            dlipc_pkg::CMD_RELAY_ON:  relay_next = 1'b1;
            dlipc_pkg::CMD_RELAY_OFF: relay_next = 1'b0;
            default:                  relay_next = relay_reg;
        endcase

        if (lights_flip) begin
            relay_next = lights_next.level;
            event_next = lights_next.level ? dlipc_pkg::EVT_LIGHTS_ON
                                           : dlipc_pkg::EVT_LIGHTS_OFF;
        end

        if (ign_flip) begin
            if (ign_next.level) begin
                power_next     = 1'b1;
                cd_active_next = 1'b0;
                cd_ms_next     = '0;
            end else begin
                cd_active_next = 1'b1;
                cd_ms_next     = cd_load;
            end
        end

        if (cd_active_next) begin
            if (cd_ms_next == '0) begin
                power_next     = 1'b0;
                cd_active_next = 1'b0;
            end else begin
                cd_ms_next = cd_ms_next - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_delay_reg <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lights_reg    <= '0;
            ign_reg       <= '0;
            relay_reg     <= 1'b0;
            power_reg     <= 1'b0;
            cd_active_reg <= 1'b0;
            cd_ms_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                off_delay_reg <= cfg_wr_data;
            end
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                lights_reg    <= lights_next;
                ign_reg       <= ign_next;
                relay_reg     <= relay_next;
                power_reg     <= power_next;
                cd_active_reg <= cd_active_next;
                cd_ms_reg     <= cd_ms_next;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_lights_reg <= s_axis_tdata[0];
            in_ign_reg    <= s_axis_tdata[1];
            in_cmd_reg    <= s_axis_tdata[3:2];
        end
        if (advance) begin
            out_relay_reg <= relay_next;
            out_power_reg <= power_next;
            out_event_reg <= event_next;
        end
    end

    a_cd_only_when_ign_low: assert property (@(posedge aclk) disable iff (!aresetn)
        cd_active_reg |-> !ign_reg.level)
        else $error("countdown running while ignition debounced high");

    a_lights_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        lights_reg.count < dlipc_pkg::DEB_CNT_W'(dlipc_pkg::DEBOUNCE_TICKS))
        else $error("lights debounce count out of range");

    a_ign_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ign_reg.count < dlipc_pkg::DEB_CNT_W'(dlipc_pkg::DEBOUNCE_TICKS))
        else $error("ignition debounce count out of range");

    a_advance_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("processed request produced no result");

    a_stall_means_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a blocked result");

endmodule
